// ----- src/glss_pkg.sv -----
// shared types, constants and the gaussian lookup table for the line spectrum summer
// no dependencies; used by every module of the block except glss_ram
package glss_pkg;

   localparam int TBL_BITS = 8;
   localparam int EXP_TABLE_SIZE = 1 << TBL_BITS;
   // z is Q.24; the table spans z in [0,8), so z below 2^27 is in range
   localparam int Z_WIDTH = 49;
   localparam int Z_RANGE_BITS = 27;
   localparam int IDX_SHIFT = Z_RANGE_BITS - TBL_BITS;

   localparam logic [2:0] REG_SWEEP_START = 3'd0;
   localparam logic [2:0] REG_SWEEP_END = 3'd1;
   localparam logic [2:0] REG_SWEEP_STEP = 3'd2;
   localparam logic [2:0] REG_INV_SIGMA = 3'd3;
   localparam logic [2:0] REG_PEAK_SCALE = 3'd4;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_STEP = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_STEP,
      OP_CLEAR
   } op_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [23:0] line_energy;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] point_energy;
      logic [31:0]        intensity;
      logic               last_point;
      logic               past_end;
   } rsp_payload_type;

   typedef struct packed {
      op_type             op;
      logic signed [23:0] line_energy;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic signed [23:0] sweep_start;
      logic signed [23:0] sweep_end;
      logic [22:0]        sweep_step;
      logic [23:0]        inv_sigma;
      logic [23:0]        peak_scale;
   } cfg_type;

   typedef logic [15:0] gauss_rom_type [EXP_TABLE_SIZE];

   // floor quotient by shift and subtract, used only while the table is built
   function automatic logic [63:0] series_quotient(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-z*z/2) in Q0.16: series of exp(-x/64) in Q30, squared six times
   function automatic gauss_rom_type gauss_rom_build();
      gauss_rom_type rom;
      logic [63:0]   x;
      logic [63:0]   u;
      logic [63:0]   r;
      logic [63:0]   e;
      logic [63:0]   q30_one;
      q30_one = 64'd1 << 30;
      for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
         // table size squared is a power of two
         x = ((64'd32 * 64'(k) * 64'(k)) << 30) >> (2 * TBL_BITS);
         u = x >> 6;
         r = q30_one;
         for (int n = 12; n >= 1; n--) begin
            r = q30_one - series_quotient((u * r) >> 30, 64'(n));
         end
         for (int i = 0; i < 6; i++) begin
            r = (r * r) >> 30;
         end
         e = (r * 64'd65536 + (64'd1 << 29)) >> 30;
         if (e > 64'd65535) begin
            e = 64'd65535;
         end
         rom[k] = e[15:0];
      end
      return rom;
   endfunction

   localparam gauss_rom_type GAUSS_ROM = gauss_rom_build();

endpackage

// ----- src/gaussian_line_spectrum_sum_top.sv -----
// Gaussian line spectrum summer. Requests carry a command: load stores one line
// centre energy (dropped when the store is full), clear empties the store and puts
// the sweep back at sweep_start, step returns one spectral point. Load and clear
// return nothing; an unused command code is taken and dropped.
// A front queue of two requests takes requests while the back end works, so
// req_stall rises only when two requests wait. The back end handles one request
// at a time: a step over N stored lines reads one line per cycle through the
// store read port and a three stage multiply and lookup pipeline. A finished
// sweep or an empty store answers in the next cycle. Results sit in an output
// register; while rsp_stall is high it holds and the back end does not start the
// next step, but loads and clears still proceed. Synchronous reset empties the
// queue and store, sets registers to their defaults and the sweep to zero; no
// clearing pass of the store is needed. Registers must be written over the csr
// port only while the block is idle; the block itself does not enforce this.
// depends on glss_pkg, glss_front, glss_back and glss_ram
module gaussian_line_spectrum_sum_top #(
   parameter int MAX_LINES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  glss_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output glss_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [4:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   glss_pkg::cfg_type        cfg_ff;
   glss_pkg::queue_head_type head;
   logic                     pop;
   logic                     wr;
   logic [2:0]               idx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_start <= 24'sd0;
         cfg_ff.sweep_end <= 24'sd25600;
         cfg_ff.sweep_step <= 23'd256;
         cfg_ff.inv_sigma <= 24'd154350;
         cfg_ff.peak_scale <= 24'd61591;
      end else if (wr) begin
         unique case (idx)
            glss_pkg::REG_SWEEP_START: cfg_ff.sweep_start <= csr_pwdata[23:0];
            glss_pkg::REG_SWEEP_END:   cfg_ff.sweep_end <= csr_pwdata[23:0];
            glss_pkg::REG_SWEEP_STEP:  cfg_ff.sweep_step <= csr_pwdata[22:0];
            glss_pkg::REG_INV_SIGMA:   cfg_ff.inv_sigma <= csr_pwdata[23:0];
            glss_pkg::REG_PEAK_SCALE:  cfg_ff.peak_scale <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         glss_pkg::REG_SWEEP_START: csr_prdata = {8'd0, cfg_ff.sweep_start};
         glss_pkg::REG_SWEEP_END:   csr_prdata = {8'd0, cfg_ff.sweep_end};
         glss_pkg::REG_SWEEP_STEP:  csr_prdata = {9'd0, cfg_ff.sweep_step};
         glss_pkg::REG_INV_SIGMA:   csr_prdata = {8'd0, cfg_ff.inv_sigma};
         glss_pkg::REG_PEAK_SCALE:  csr_prdata = {8'd0, cfg_ff.peak_scale};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   glss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   glss_back #(.MAX_LINES(MAX_LINES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/glss_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module glss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/glss_front.sv -----
// front end: accepts requests, classifies commands and queues them for the back end
// depends on glss_pkg
module glss_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  glss_pkg::req_payload_type req_payload,
   output glss_pkg::queue_head_type head,
   input  logic                     pop
);

   glss_pkg::queue_item_type slot_ff [2];
   glss_pkg::queue_item_type slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;
   glss_pkg::queue_item_type item;

   always_comb begin
      item.line_energy = req_payload.line_energy;
      item.op = glss_pkg::OP_LOAD;
      unique case (req_payload.cmd)
         glss_pkg::CMD_LOAD:  item.op = glss_pkg::OP_LOAD;
         glss_pkg::CMD_STEP:  item.op = glss_pkg::OP_STEP;
         glss_pkg::CMD_CLEAR: item.op = glss_pkg::OP_CLEAR;
         default:             item.op = glss_pkg::OP_LOAD;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   // unused command code is taken and dropped
   assign push = req_valid && !req_stall && (req_payload.cmd != glss_pkg::CMD_UNUSED);
   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      slot_in = slot_ff;
      count_in = count_ff;
      if (do_pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && do_pop)) begin
            slot_in[0] = item;
         end else begin
            slot_in[1] = item;
         end
      end
      count_in = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item = slot_ff[0];

endmodule

// ----- src/glss_back.sv -----
// back end: line store, sweep state and the pipelined gaussian accumulation
// depends on glss_pkg and glss_ram
module glss_back #(
   parameter int MAX_LINES = 1024,
   localparam int CW = $clog2(MAX_LINES + 1),
   localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  glss_pkg::queue_head_type  head,
   output logic                      pop,
   input  glss_pkg::cfg_type         cfg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output glss_pkg::rsp_payload_type rsp_payload
);

   glss_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic signed [24:0]  energy_ff, energy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   glss_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic        wr_en;
   logic        rd_en;
   logic [23:0] rd_data;

   // accumulation pipeline
   logic                          p1_ff;
   logic                          p2_ff;
   logic                          p3_ff;
   logic [glss_pkg::Z_WIDTH-1:0]  z_ff;
   logic [23:0]                   term_ff;
   logic [31:0]                   sum_ff, sum_in;

   logic signed [25:0] diff;
   logic [24:0]        abs_diff;
   logic [15:0]        entry;
   logic [39:0]        prod;
   logic [32:0]        acc;
   logic               out_free;
   logic               past;
   logic               last;
   logic signed [25:0] next_energy;

   glss_ram #(.WIDTH(24), .DEPTH(MAX_LINES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (head.item.line_energy),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign diff = {energy_ff[24], energy_ff} - {{2{rd_data[23]}}, rd_data};
   assign abs_diff = diff[25] ? 25'(-diff) : diff[24:0];
   assign entry = (z_ff[glss_pkg::Z_WIDTH-1:glss_pkg::Z_RANGE_BITS] == '0)
      ? glss_pkg::GAUSS_ROM[z_ff[glss_pkg::Z_RANGE_BITS-1:glss_pkg::IDX_SHIFT]] : 16'd0;
   assign prod = 40'(cfg.peak_scale) * 40'(entry);
   assign acc = {1'b0, sum_ff} + 33'(term_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign past = (energy_ff >= 25'(cfg.sweep_end));
   assign next_energy = 26'(energy_ff) + 26'(cfg.sweep_step);
   assign last = (next_energy >= 26'(cfg.sweep_end));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      energy_in = energy_ff;
      sum_in = sum_ff;
      pop = 1'b0;
      wr_en = 1'b0;
      rd_en = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      if (p3_ff) begin
         sum_in = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
      unique case (state_ff)
         glss_pkg::ST_IDLE: begin
            if (head.valid) begin
               unique case (head.item.op)
                  glss_pkg::OP_LOAD: begin
                     pop = 1'b1;
                     if (count_ff < CW'(MAX_LINES)) begin
                        wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  glss_pkg::OP_CLEAR: begin
                     pop = 1'b1;
                     count_in = '0;
                     energy_in = 25'(cfg.sweep_start);
                  end
                  glss_pkg::OP_STEP: begin
                     if (out_free) begin
                        pop = 1'b1;
                        if (past) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = '{point_energy: '0, intensity: '0,
                                      last_point: 1'b0, past_end: 1'b1};
                        end else if (count_ff == '0) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = '{point_energy: energy_ff[23:0], intensity: '0,
                                      last_point: last, past_end: 1'b0};
                           energy_in = next_energy[24:0];
                        end else begin
                           issue_in = '0;
                           sum_in = '0;
                           state_in = glss_pkg::ST_SUM;
                        end
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         glss_pkg::ST_SUM: begin
            if (issue_ff != count_ff) begin
               rd_en = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!p1_ff && !p2_ff && !p3_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{point_energy: energy_ff[23:0], intensity: sum_ff,
                          last_point: last, past_end: 1'b0};
               energy_in = next_energy[24:0];
               state_in = glss_pkg::ST_IDLE;
            end
         end
         default: state_in = glss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glss_pkg::ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         energy_ff <= '0;
         rsp_valid_ff <= 1'b0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         p3_ff <= 1'b0;
         sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         energy_ff <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff <= rd_en;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         sum_ff <= sum_in;
      end
      z_ff <= glss_pkg::Z_WIDTH'(abs_diff) * glss_pkg::Z_WIDTH'(cfg.inv_sigma);
      term_ff <= prod[39:16];
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- tb/tb_gaussian_line_spectrum_sum_top.sv -----
// self-checking testbench for the gaussian line spectrum summer: sends load, step,
// clear and unused requests, predicts each spectral point and compares results
// depends on glss_pkg and gaussian_line_spectrum_sum_top
module tb_gaussian_line_spectrum_sum_top;

   localparam int STORE_DEPTH = 1024;
   localparam int GAUSS_ENTRIES = 256;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   glss_pkg::req_payload_type     req_payload;
   logic                          rsp_valid;
   logic                          rsp_stall;
   glss_pkg::rsp_payload_type     rsp_payload;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [4:0]                    csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   // predictor state
   glss_pkg::cfg_type             sweep_cfg;
   int                            line_centres [STORE_DEPTH];
   int                            line_total;
   longint                        sweep_pos;
   logic [15:0]                   gauss_lut [GAUSS_ENTRIES];

   glss_pkg::rsp_payload_type     pending_points [$];
   int                            error_count;
   bit                            no_idle;
   int                            stall_hold;

   gaussian_line_spectrum_sum_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // exp(-z*z/2) in Q0.16 via a Q30 series of exp(-x/64) raised to the 64th power
   function automatic void fill_gauss_lut();
      longint unsigned one_q30;
      longint unsigned xq;
      longint unsigned uq;
      longint unsigned acc;
      longint unsigned rounded;
      one_q30 = 64'd1 << 30;
      for (int k = 0; k < GAUSS_ENTRIES; k++) begin
         xq = ((64'd32 * k * k) << 30) / (GAUSS_ENTRIES * GAUSS_ENTRIES);
         uq = xq >> 6;
         acc = one_q30;
         for (int n = 12; n >= 1; n--) begin
            acc = one_q30 - ((uq * acc) >> 30) / n;
         end
         for (int s = 0; s < 6; s++) begin
            acc = (acc * acc) >> 30;
         end
         rounded = (acc * 64'd65536 + (64'd1 << 29)) >> 30;
         gauss_lut[k] = (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
      end
   endfunction

   function automatic glss_pkg::rsp_payload_type next_spectrum_point();
      glss_pkg::rsp_payload_type pt;
      longint unsigned total;
      longint unsigned offset;
      longint unsigned zq;
      longint unsigned slot;
      longint          diff;
      pt = '0;
      if (sweep_pos >= longint'(sweep_cfg.sweep_end)) begin
         pt.past_end = 1'b1;
         return pt;
      end
      total = 0;
      for (int i = 0; i < line_total; i++) begin
         diff = sweep_pos - line_centres[i];
         offset = (diff < 0) ? -diff : diff;
         zq = offset * sweep_cfg.inv_sigma;
         slot = zq >> 19;
         if (slot < GAUSS_ENTRIES) begin
            total += (longint'(sweep_cfg.peak_scale) * gauss_lut[slot]) >> 16;
         end
      end
      pt.point_energy = sweep_pos[23:0];
      pt.intensity = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      pt.last_point = (sweep_pos + longint'(sweep_cfg.sweep_step)
                       >= longint'(sweep_cfg.sweep_end));
      sweep_pos += sweep_cfg.sweep_step;
      return pt;
   endfunction

   function automatic void apply_request(glss_pkg::req_payload_type rq);
      case (rq.cmd)
         glss_pkg::CMD_LOAD: begin
            if (line_total < STORE_DEPTH) begin
               line_centres[line_total] = rq.line_energy;
               line_total++;
            end
         end
         glss_pkg::CMD_CLEAR: begin
            line_total = 0;
            sweep_pos = sweep_cfg.sweep_start;
         end
         glss_pkg::CMD_STEP: pending_points = {pending_points, next_spectrum_point()};
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(logic [1:0] cmd, logic signed [23:0] energy);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{cmd: cmd, line_energy: energy};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      apply_request('{cmd: cmd, line_energy: energy});
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) begin
         @(posedge clock);
      end
      // loads or clears may still sit in the front queue
      repeat (20) @(posedge clock);
   endtask

   // leaves the bus selected so writes can follow back to back
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      case (idx)
         glss_pkg::REG_SWEEP_START: sweep_cfg.sweep_start = value[23:0];
         glss_pkg::REG_SWEEP_END: sweep_cfg.sweep_end = value[23:0];
         glss_pkg::REG_SWEEP_STEP: sweep_cfg.sweep_step = value[22:0];
         glss_pkg::REG_INV_SIGMA: sweep_cfg.inv_sigma = value[23:0];
         glss_pkg::REG_PEAK_SCALE: sweep_cfg.peak_scale = value[23:0];
         default: ;
      endcase
   endtask

   task automatic set_sweep(int first, int stop, int incr, int inv_sig, int scale);
      drain_points();
      write_reg(glss_pkg::REG_SWEEP_START, first);
      write_reg(glss_pkg::REG_SWEEP_END, stop);
      write_reg(glss_pkg::REG_SWEEP_STEP, incr);
      write_reg(glss_pkg::REG_INV_SIGMA, inv_sig);
      write_reg(glss_pkg::REG_PEAK_SCALE, scale);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // line centre near some point of the current sweep so gaussians overlap
   function automatic logic signed [23:0] near_line();
      longint c;
      c = longint'(sweep_cfg.sweep_start)
          + longint'(sweep_cfg.sweep_step) * $urandom_range(0, 12)
          + $signed($urandom_range(0, 1600)) - 800;
      return c[23:0];
   endfunction

   task automatic test_default_sweep();
      send_request(glss_pkg::CMD_LOAD, 24'sd2560);
      send_request(glss_pkg::CMD_LOAD, 24'sd2700);
      send_request(glss_pkg::CMD_LOAD, 24'sd12800);
      for (int i = 0; i < 12; i++) begin
         send_request(glss_pkg::CMD_STEP, 24'($urandom));
      end
   endtask

   task automatic test_commands();
      send_request(glss_pkg::CMD_UNUSED, 24'($urandom));
      send_request(glss_pkg::CMD_CLEAR, 24'sd0);
      send_request(glss_pkg::CMD_STEP, 24'sd0);
      send_request(glss_pkg::CMD_LOAD, 24'sh800000);
      send_request(glss_pkg::CMD_LOAD, 24'sd8388607);
      send_request(glss_pkg::CMD_LOAD, 24'sd0);
      send_request(glss_pkg::CMD_STEP, 24'sd0);
      send_request(glss_pkg::CMD_UNUSED, 24'sd0);
      send_request(glss_pkg::CMD_STEP, 24'sd0);
   endtask

   task automatic test_config_extremes();
      // widest sweep, largest step: ends after three points then reports past end
      set_sweep(-8388608, 8388607, 8388607, 0, 16777215);
      send_request(glss_pkg::CMD_CLEAR, 24'sd0);
      send_request(glss_pkg::CMD_LOAD, 24'sh800000);
      send_request(glss_pkg::CMD_LOAD, 24'sd8388607);
      for (int i = 0; i < 5; i++) begin
         send_request(glss_pkg::CMD_STEP, 24'sd0);
      end
      // sharpest gaussian, full scale, many equal lines: the sum saturates
      set_sweep(0, 8388607, 1, 16777215, 16777215);
      send_request(glss_pkg::CMD_CLEAR, 24'sd0);
      for (int i = 0; i < 300; i++) begin
         send_request(glss_pkg::CMD_LOAD, 24'sd0);
      end
      send_request(glss_pkg::CMD_STEP, 24'sd0);
      send_request(glss_pkg::CMD_STEP, 24'sd0);
      // zero scale and an empty sweep
      set_sweep(100, 100, 1, 154350, 0);
      send_request(glss_pkg::CMD_CLEAR, 24'sd0);
      send_request(glss_pkg::CMD_LOAD, 24'sd100);
      send_request(glss_pkg::CMD_STEP, 24'sd0);
   endtask

   task automatic test_store_full();
      set_sweep(0, 2560, 256, 154350, 61591);
      send_request(glss_pkg::CMD_CLEAR, 24'sd0);
      for (int i = 0; i < STORE_DEPTH + 6; i++) begin
         send_request(glss_pkg::CMD_LOAD, 24'($urandom_range(0, 2560)));
      end
      send_request(glss_pkg::CMD_STEP, 24'sd0);
      send_request(glss_pkg::CMD_STEP, 24'sd0);
   endtask

   task automatic test_random_sweeps();
      int items;
      int n;
      items = 0;
      while (items < 580) begin
         no_idle = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 2) == 0) begin
            set_sweep($signed($urandom_range(0, 20000)) - 10000, $urandom_range(0, 12000),
                      $urandom_range(1, 600), $urandom_range(20000, 400000),
                      $urandom_range(0, 16777215));
         end
         send_request(glss_pkg::CMD_CLEAR, 24'($urandom));
         n = $urandom_range(0, 24);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(glss_pkg::CMD_LOAD, 24'($urandom));
            end else begin
               send_request(glss_pkg::CMD_LOAD, near_line());
            end
         end
         n = $urandom_range(1, 16);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 14) == 0) begin
               send_request(glss_pkg::CMD_UNUSED, 24'($urandom));
            end else begin
               send_request(glss_pkg::CMD_STEP, 24'($urandom));
            end
         end
         items += 25;
      end
      no_idle = 1'b0;
   endtask

   // result stall: mostly short bursts, now and then a long hold
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 19))
            0: stall_hold <= $urandom_range(10, 60);
            1, 2, 3, 4: rsp_stall <= 1'b1;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      glss_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected spectral point %p", $time, rsp_payload);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_payload.point_energy !== want.point_energy) begin
               $display("%0t: point_energy expected %0d actual %0d", $time,
                        want.point_energy, rsp_payload.point_energy);
               error_count++;
            end
            if (rsp_payload.intensity !== want.intensity) begin
               $display("%0t: intensity expected %0h actual %0h", $time,
                        want.intensity, rsp_payload.intensity);
               error_count++;
            end
            if (rsp_payload.last_point !== want.last_point) begin
               $display("%0t: last_point expected %0b actual %0b", $time,
                        want.last_point, rsp_payload.last_point);
               error_count++;
            end
            if (rsp_payload.past_end !== want.past_end) begin
               $display("%0t: past_end expected %0b actual %0b", $time,
                        want.past_end, rsp_payload.past_end);
               error_count++;
            end
         end
      end
   end

   initial begin
      int wait_cycles;
      error_count = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sweep_cfg = '{sweep_start: 24'sd0, sweep_end: 24'sd25600, sweep_step: 23'd256,
                    inv_sigma: 24'd154350, peak_scale: 24'd61591};
      line_total = 0;
      sweep_pos = 0;
      fill_gauss_lut();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_sweep();
      test_commands();
      test_config_extremes();
      test_store_full();
      test_random_sweeps();

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_points.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_points.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/glss_pkg.sv
src/glss_ram.sv
src/glss_front.sv
src/glss_back.sv
src/gaussian_line_spectrum_sum_top.sv
tb/tb_gaussian_line_spectrum_sum_top.sv
